[rtl/core/fcc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_pkg: shared types and constants of the frustum cull classifier
// Plane count, coefficient widths, operation and class codes, and the
// descriptor word that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package fcc_pkg;

	localparam int NumPlanes  = 6;
	localparam int CoefWidth  = 32;
	localparam int FracBits   = 16;
	localparam int PlaneBits  = 3;
	localparam int QueueDepth = 2;

	// Products are 32x32 = 64 bits; a sum of four plus a box term fits in 70.
	localparam int AccWidth = 70;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_POINT  = 2'd1,
		OP_SPHERE = 2'd2,
		OP_BOX    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CLASS_INSIDE    = 2'd0,
		CLASS_INTERSECT = 2'd1,
		CLASS_OUTSIDE   = 2'd2
	} class_t;

	// Test word handed to the back end.
	typedef struct packed {
		op_t                op;
		logic signed [31:0] vec_x;
		logic signed [31:0] vec_y;
		logic signed [31:0] vec_z;
		logic [30:0]        radius;
		logic [30:0]        half_x;
		logic [30:0]        half_y;
		logic [30:0]        half_z;
	} test_t;

	typedef struct packed {
		logic signed [CoefWidth-1:0] a;
		logic signed [CoefWidth-1:0] b;
		logic signed [CoefWidth-1:0] c;
		logic signed [CoefWidth-1:0] d;
	} plane_t;

endpackage

[rtl/core/frustum_cull_classifier.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_cull_classifier: six-plane view frustum culling
// Loads clip planes and classifies points, spheres and boxes against them.
// ----------------------------------------------------------------------------
// A load word writes one plane (a, b, c, d in Q16.16) and gives no result; a
// load with a plane index of six or more is dropped. A test word returns one
// classification: 0 inside, 1 intersecting, 2 outside. The front end queues
// up to two test words; the back end evaluates one plane per cycle on a
// single shared set of multipliers: a test starts, its six planes pass the
// product and sum stages, and its result is registered. A load waits until
// every queued test has finished so results always see the planes that were
// loaded before them. The result register lets the next test start while a
// result is still held by a stalled receiver.
module frustum_cull_classifier (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         operation,
	input  logic [2:0]         plane_index,
	input  logic signed [31:0] vec_x,
	input  logic signed [31:0] vec_y,
	input  logic signed [31:0] vec_z,
	input  logic signed [31:0] plane_offset,
	input  logic [30:0]        radius,
	input  logic [30:0]        half_x,
	input  logic [30:0]        half_y,
	input  logic [30:0]        half_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         classification
);

	fcc_pkg::plane_t planes [fcc_pkg::NumPlanes];
	fcc_pkg::test_t  q_word;
	logic            q_valid, q_pop, busy;

	fcc_front u_front (
		.clk, .arst_n, .valid(in_valid), .stall(in_stall), .operation,
		.plane_index, .vec_x, .vec_y, .vec_z, .plane_offset, .radius,
		.half_x, .half_y, .half_z, .busy, .planes, .q_valid, .q_word, .q_pop
	);

	fcc_back u_back (
		.clk, .arst_n, .planes, .q_valid, .q_word, .q_pop, .busy,
		.out_valid, .out_stall, .classification
	);

endmodule

[rtl/core/fcc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_front: input decode and plane store
// Writes plane loads into the store and pushes test words into a short queue.
// ----------------------------------------------------------------------------
module fcc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid,
	output logic                 stall,
	input  logic [1:0]           operation,
	input  logic [2:0]           plane_index,
	input  logic signed [31:0]   vec_x,
	input  logic signed [31:0]   vec_y,
	input  logic signed [31:0]   vec_z,
	input  logic signed [31:0]   plane_offset,
	input  logic [30:0]          radius,
	input  logic [30:0]          half_x,
	input  logic [30:0]          half_y,
	input  logic [30:0]          half_z,
	input  logic                 busy,
	output fcc_pkg::plane_t      planes [fcc_pkg::NumPlanes],
	output logic                 q_valid,
	output fcc_pkg::test_t       q_word,
	input  logic                 q_pop
);

	fcc_pkg::plane_t planes_q [fcc_pkg::NumPlanes];
	fcc_pkg::test_t  mem_q [fcc_pkg::QueueDepth];
	logic            wr_ptr_q, rd_ptr_q;
	logic [1:0]      cnt_q;
	logic            is_load, push, full;

	assign is_load = (fcc_pkg::op_t'(operation) == fcc_pkg::OP_LOAD);
	assign full    = (cnt_q == 2'(fcc_pkg::QueueDepth));
	// A load must not change planes under a test still queued or running.
	assign stall   = is_load ? (cnt_q != 2'd0 || busy) : full;
	assign push    = valid && !stall && !is_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fcc_pkg::NumPlanes; i++) begin
				planes_q[i] <= '0;
			end
		end else if (valid && !stall && is_load
				&& plane_index < 3'(fcc_pkg::NumPlanes)) begin
			planes_q[plane_index] <= '{vec_x, vec_y, vec_z, plane_offset};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{fcc_pkg::op_t'(operation), vec_x, vec_y, vec_z,
				radius, half_x, half_y, half_z};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

	assign planes  = planes_q;
	assign q_valid = (cnt_q != 2'd0);
	assign q_word  = mem_q[rd_ptr_q];

endmodule

[rtl/core/fcc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_back: per-plane distance evaluation and classification
// One multiplier set shared across planes; each plane passes a product stage
// and a sum stage, overlapped, so one plane finishes each cycle.
// ----------------------------------------------------------------------------
module fcc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fcc_pkg::plane_t      planes [fcc_pkg::NumPlanes],
	input  logic                 q_valid,
	input  fcc_pkg::test_t       q_word,
	output logic                 q_pop,
	output logic                 busy,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           classification
);

	localparam int W = fcc_pkg::AccWidth;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_OUT  = 3'b100
	} state_t;

	state_t                 state_q;
	fcc_pkg::test_t         item_q;
	logic [2:0]             issue_q;
	logic                   prod_vld_s1;
	logic [2:0]             prod_idx_s1;
	logic signed [63:0]     px_s1, py_s1, pz_s1, pd_s1, ha_s1, hb_s1, hc_s1;
	logic [1:0]             class_q;
	logic [1:0]             res_q;
	logic                   res_vld_q;
	logic                   res_load;

	fcc_pkg::plane_t        pl;
	logic signed [W-1:0]    center_dist, rad_w, ta, tb, tc, tmin, corner;
	logic                   any_neg, all_neg;
	logic [1:0]             plane_class;

	assign pl = planes[issue_q];

	// Stage 1: products for the plane being issued.
	always_ff @(posedge clk) begin
		px_s1 <= 64'(pl.a) * 64'(item_q.vec_x);
		py_s1 <= 64'(pl.b) * 64'(item_q.vec_y);
		pz_s1 <= 64'(pl.c) * 64'(item_q.vec_z);
		pd_s1 <= 64'(pl.d) <<< fcc_pkg::FracBits;
		ha_s1 <= 64'(pl.a) * $signed({33'd0, item_q.half_x});
		hb_s1 <= 64'(pl.b) * $signed({33'd0, item_q.half_y});
		hc_s1 <= 64'(pl.c) * $signed({33'd0, item_q.half_z});
		prod_idx_s1 <= issue_q;
	end

	// Stage 2: distance and corner tests.
	always_comb begin
		center_dist = W'(px_s1) + W'(py_s1) + W'(pz_s1) + W'(pd_s1);
		rad_w = W'({item_q.radius, 16'd0});
		ta = (ha_s1 < 0) ? -W'(ha_s1) : W'(ha_s1);
		tb = (hb_s1 < 0) ? -W'(hb_s1) : W'(hb_s1);
		tc = (hc_s1 < 0) ? -W'(hc_s1) : W'(hc_s1);
		tmin = ta + tb + tc;
		// Nearest corner center_dist - tmin; farthest center_dist + tmin.
		corner  = center_dist + tmin;
		all_neg = corner[W-1];
		any_neg = (center_dist < tmin);
		plane_class = fcc_pkg::CLASS_INSIDE;
		case (item_q.op)
			fcc_pkg::OP_POINT: begin
				if (center_dist[W-1]) plane_class = fcc_pkg::CLASS_OUTSIDE;
			end
			fcc_pkg::OP_SPHERE: begin
				if (center_dist < -rad_w) plane_class = fcc_pkg::CLASS_OUTSIDE;
				else if (center_dist < rad_w) plane_class = fcc_pkg::CLASS_INTERSECT;
			end
			fcc_pkg::OP_BOX: begin
				if (all_neg) plane_class = fcc_pkg::CLASS_OUTSIDE;
				else if (any_neg) plane_class = fcc_pkg::CLASS_INTERSECT;
			end
			default: plane_class = fcc_pkg::CLASS_INSIDE;
		endcase
	end

	assign q_pop    = (state_q == ST_IDLE) && q_valid;
	assign busy     = (state_q != ST_IDLE) || res_vld_q;
	assign res_load = (state_q == ST_OUT) && (!res_vld_q || !out_stall);

	always_ff @(posedge clk) begin
		if (q_pop) item_q <= q_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issue_q     <= 3'd0;
			prod_vld_s1 <= 1'b0;
			class_q     <= fcc_pkg::CLASS_INSIDE;
			res_q       <= fcc_pkg::CLASS_INSIDE;
			res_vld_q   <= 1'b0;
		end else begin
			if (res_load) res_vld_q <= 1'b1;
			else if (!out_stall) res_vld_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						state_q     <= ST_RUN;
						issue_q     <= 3'd0;
						prod_vld_s1 <= 1'b0;
						class_q     <= fcc_pkg::CLASS_INSIDE;
					end
				end
				ST_RUN: begin
					prod_vld_s1 <= (issue_q != 3'(fcc_pkg::NumPlanes));
					if (issue_q != 3'(fcc_pkg::NumPlanes)) issue_q <= issue_q + 3'd1;
					if (prod_vld_s1) begin
						if (plane_class == fcc_pkg::CLASS_OUTSIDE ||
								class_q == fcc_pkg::CLASS_OUTSIDE)
							class_q <= fcc_pkg::CLASS_OUTSIDE;
						else if (plane_class == fcc_pkg::CLASS_INTERSECT)
							class_q <= fcc_pkg::CLASS_INTERSECT;
						if (prod_idx_s1 == 3'(fcc_pkg::NumPlanes - 1))
							state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (res_load) begin
						res_q   <= class_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid      = res_vld_q;
	assign classification = res_q;

endmodule

[tb/sv/tb_frustum_cull_classifier.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frustum_cull_classifier: self-checking bench for the frustum classifier
// Plane loads and point, sphere and box tests are sent with random gaps and
// random output stalls. Every test result is checked against a classification
// that the bench works out itself with exact 128-bit arithmetic.
// ----------------------------------------------------------------------------
module tb_frustum_cull_classifier;
	import fcc_pkg::*;

	// One input word, one field per port.
	typedef struct {
		op_t                op;
		logic [2:0]         idx;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic signed [31:0] d;
		logic [30:0]        r;
		logic [30:0]        hx;
		logic [30:0]        hy;
		logic [30:0]        hz;
	} word_t;

	localparam int WatchdogLimit = 20000;
	localparam int HoldCycles    = 600;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         operation;
	logic [2:0]         plane_index;
	logic signed [31:0] vec_x;
	logic signed [31:0] vec_y;
	logic signed [31:0] vec_z;
	logic signed [31:0] plane_offset;
	logic [30:0]        radius;
	logic [30:0]        half_x;
	logic [30:0]        half_y;
	logic [30:0]        half_z;
	logic               out_valid;
	logic               out_stall;
	logic [1:0]         classification;

	frustum_cull_classifier dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .plane_index(plane_index),
		.vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z), .plane_offset(plane_offset),
		.radius(radius), .half_x(half_x), .half_y(half_y), .half_z(half_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.classification(classification)
	);

	// Words waiting to be sent, and the classifications still owed by the block.
	word_t  send_queue[$];
	class_t owed_classes[$];

	// The bench's own copy of the plane store: a, b, c, d per plane.
	logic signed [31:0] planes[NumPlanes][4];

	int  errors;
	int  results_seen;
	int  idle_cycles;
	bit  hold_done;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Apply one word to the plane copy, or classify it. Loads return nothing.
	function automatic void apply_word(word_t w);
		logic signed [127:0] center_dist;
		logic signed [127:0] rad;
		logic signed [127:0] ta;
		logic signed [127:0] tb;
		logic signed [127:0] tc;
		logic signed [127:0] corner;
		class_t              verdict;
		int                  behind;
		verdict = CLASS_INSIDE;
		if (w.op == OP_LOAD) begin
			if (w.idx < NumPlanes) begin
				planes[w.idx][0] = w.x;
				planes[w.idx][1] = w.y;
				planes[w.idx][2] = w.z;
				planes[w.idx][3] = w.d;
			end
			return;
		end
		rad = 128'(w.r) <<< FracBits;
		for (int p = 0; p < NumPlanes && verdict != CLASS_OUTSIDE; p++) begin
			center_dist = 128'(planes[p][0]) * 128'(w.x) + 128'(planes[p][1]) * 128'(w.y)
				+ 128'(planes[p][2]) * 128'(w.z) + (128'(planes[p][3]) <<< FracBits);
			case (w.op)
				OP_POINT: begin
					if (center_dist < 0) verdict = CLASS_OUTSIDE;
				end
				OP_SPHERE: begin
					if (center_dist < -rad) verdict = CLASS_OUTSIDE;
					else if (center_dist < rad) verdict = CLASS_INTERSECT;
				end
				default: begin
					ta = 128'(planes[p][0]) * 128'({1'b0, w.hx});
					tb = 128'(planes[p][1]) * 128'({1'b0, w.hy});
					tc = 128'(planes[p][2]) * 128'({1'b0, w.hz});
					behind = 0;
					for (int c = 0; c < 8; c++) begin
						corner = center_dist + (c[0] ? ta : -ta) + (c[1] ? tb : -tb)
							+ (c[2] ? tc : -tc);
						if (corner < 0) behind++;
					end
					if (behind == 8) verdict = CLASS_OUTSIDE;
					else if (behind != 0) verdict = CLASS_INTERSECT;
				end
			endcase
		end
		owed_classes.push_back(verdict);
	endfunction

	// Q16.16 value with integer part in [-lim, lim] and a random fraction.
	function automatic logic signed [31:0] near_q(int lim);
		return 32'(($urandom_range(0, 2 * lim) - lim) <<< 16) + 32'($urandom_range(0, 65535));
	endfunction

	function automatic word_t make_word(op_t op, logic [2:0] idx,
			logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z,
			logic signed [31:0] d, logic [30:0] r, logic [30:0] hx,
			logic [30:0] hy, logic [30:0] hz);
		word_t w;
		w.op = op; w.idx = idx; w.x = x; w.y = y; w.z = z; w.d = d;
		w.r = r; w.hx = hx; w.hy = hy; w.hz = hz;
		return w;
	endfunction

	// Random word. Most are tests. Without wild, values stay near a sane frustum
	// so that all three classifications come up; with wild, they use the full field ranges.
	function automatic word_t random_word(bit wild);
		word_t w;
		w.op  = op_t'($urandom_range(0, 3));
		w.idx = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
		if (wild) begin
			w.x = $urandom; w.y = $urandom; w.z = $urandom; w.d = $urandom;
			w.r = 31'($urandom); w.hx = 31'($urandom);
			w.hy = 31'($urandom); w.hz = 31'($urandom);
		end else begin
			w.x = near_q(30); w.y = near_q(30); w.z = near_q(30);
			w.d = near_q(40);
			w.r  = 31'(near_q(8)) & 31'h7FFFFFFF;
			w.hx = 31'($urandom_range(0, 12 << 16));
			w.hy = 31'($urandom_range(0, 12 << 16));
			w.hz = 31'($urandom_range(0, 12 << 16));
			if (w.op == OP_LOAD) begin
				w.x = near_q(2); w.y = near_q(2); w.z = near_q(2);
			end
		end
		return w;
	endfunction

	// Stimulus: reset, a directed opening, then random words.
	initial begin
		logic signed [31:0] one;
		logic signed [31:0] mx;
		logic signed [31:0] mn;
		logic [30:0]        big;
		one = 32'sh0001_0000;
		mx  = 32'sh7FFF_FFFF;
		mn  = 32'sh8000_0000;
		big = 31'h7FFF_FFFF;
		errors = 0;
		for (int p = 0; p < NumPlanes; p++)
			for (int k = 0; k < 4; k++) planes[p][k] = '0;

		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Unloaded planes: zero distance everywhere, so only a sphere with a
		// nonzero radius is intersecting.
		send_queue.push_back(make_word(OP_POINT, 0, mn, mx, 0, 0, 0, 0, 0, 0));
		send_queue.push_back(make_word(OP_SPHERE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_queue.push_back(make_word(OP_SPHERE, 0, 0, 0, 0, 0, 1, 0, 0, 0));
		send_queue.push_back(make_word(OP_BOX, 0, mx, mn, mx, 0, 0, big, big, big));
		// A cube of half size ten, one plane per face but the +z face; plane five stays zero.
		send_queue.push_back(make_word(OP_LOAD, 0, one, 0, 0, 10 * one, 0, 0, 0, 0));
		send_queue.push_back(make_word(OP_LOAD, 1, -one, 0, 0, 10 * one, 0, 0, 0, 0));
		send_queue.push_back(make_word(OP_LOAD, 2, 0, one, 0, 10 * one, 0, 0, 0, 0));
		send_queue.push_back(make_word(OP_LOAD, 3, 0, -one, 0, 10 * one, 0, 0, 0, 0));
		send_queue.push_back(make_word(OP_LOAD, 4, 0, 0, one, 10 * one, 0, 0, 0, 0));
		// Plane indexes six and seven are dropped.
		send_queue.push_back(make_word(OP_LOAD, 6, 0, 0, -one, mn, 0, 0, 0, 0));
		send_queue.push_back(make_word(OP_LOAD, 7, mn, mn, mn, mn, 0, 0, 0, 0));
		send_queue.push_back(make_word(OP_POINT, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_queue.push_back(make_word(OP_POINT, 0, -11 * one, 0, 0, 0, 0, 0, 0, 0));
		send_queue.push_back(make_word(OP_SPHERE, 0, 0, 0, 0, 0, 31'(5 * one), 0, 0, 0));
		send_queue.push_back(make_word(OP_SPHERE, 0, 8 * one, 0, 0, 0, 31'(5 * one), 0, 0, 0));
		send_queue.push_back(make_word(OP_SPHERE, 0, 0, 16 * one, 0, 0, 31'(5 * one), 0, 0, 0));
		send_queue.push_back(make_word(OP_BOX, 0, 0, 0, 0, 0, 0,
			31'(2 * one), 31'(2 * one), 31'(2 * one)));
		send_queue.push_back(make_word(OP_BOX, 0, 9 * one, 0, 0, 0, 0, 31'(2 * one), 0, 0));
		send_queue.push_back(make_word(OP_BOX, 0, 0, 0, -13 * one, 0, 0, 0, 0, 31'(2 * one)));
		// Extreme coefficients and extreme test fields.
		send_queue.push_back(make_word(OP_LOAD, 5, mx, mn, mx, mn, 0, 0, 0, 0));
		send_queue.push_back(make_word(OP_POINT, 0, mn, mn, mn, 0, 0, 0, 0, 0));
		send_queue.push_back(make_word(OP_SPHERE, 0, mx, mx, mn, 0, big, 0, 0, 0));
		send_queue.push_back(make_word(OP_BOX, 0, mn, mx, mn, 0, 0, big, big, big));
		send_queue.push_back(make_word(OP_LOAD, 5, 0, 0, 0, 0, 0, 0, 0, 0));

		// Random part: mostly tests with moderate values, a share of full-range
		// words, in bursts.
		for (int i = 0; i < 1600; i++)
			send_queue.push_back(random_word($urandom_range(0, 4) == 0));

		wait (send_queue.size() == 0);
		@(posedge clk);
		while (in_valid || owed_classes.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0 && owed_classes.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Driver: a word accepted at this edge goes to the predictor, then the next
	// word comes up after a random gap. Gaps come in bursts so that stretches
	// without idling also occur.
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		word_t w;
		bit    free;
		if (!arst_n) begin
			in_valid     <= 1'b0;
			operation    <= OP_LOAD;
			plane_index  <= '0;
			vec_x        <= '0;
			vec_y        <= '0;
			vec_z        <= '0;
			plane_offset <= '0;
			radius       <= '0;
			half_x       <= '0;
			half_y       <= '0;
			half_z       <= '0;
			gap_left     <= 0;
		end else begin
			free = !in_valid || !in_stall;
			if (in_valid && !in_stall) begin
				w = make_word(op_t'(operation), plane_index, vec_x, vec_y, vec_z,
					plane_offset, radius, half_x, half_y, half_z);
				apply_word(w);
			end
			if (free) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (send_queue.size() != 0) begin
					w = send_queue.pop_front();
					operation    <= w.op;
					plane_index  <= w.idx;
					vec_x        <= w.x;
					vec_y        <= w.y;
					vec_z        <= w.z;
					plane_offset <= w.d;
					radius       <= w.r;
					half_x       <= w.hx;
					half_y       <= w.hy;
					half_z       <= w.hz;
					in_valid     <= 1'b1;
					gap_left     <= (((send_queue.size() / 64) % 2) == 0) ?
						$urandom_range(0, 16) : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each accepted classification against the oldest one owed,
	// and stalls the output at random. Once, after a few hundred results, it
	// holds off for a long stretch so that the block fills and stalls its input.
	int stall_left;
	int hold_left;
	always @(posedge clk or negedge arst_n) begin
		class_t want;
		if (!arst_n) begin
			out_stall    <= 1'b0;
			stall_left   <= 0;
			hold_left    <= 0;
			hold_done    <= 1'b0;
			results_seen <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen <= results_seen + 1;
				if (owed_classes.size() == 0) begin
					errors++;
					$display("%0t: unexpected classification, expected none actual %0d",
						$realtime, classification);
				end else begin
					want = owed_classes.pop_front();
					if (classification !== want) begin
						errors++;
						$display("%0t: classification mismatch, expected %0d actual %0d",
							$realtime, want, classification);
					end
				end
				stall_left <= (((results_seen / 50) % 2) == 0) ? $urandom_range(0, 16) : 0;
				out_stall  <= 1'b0;
			end else if (!hold_done && results_seen == 300) begin
				hold_done <= 1'b1;
				hold_left <= HoldCycles;
				out_stall <= 1'b1;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_stall  <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: cycles in which neither side moves a word.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WatchdogLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

[sim.f]
rtl/core/fcc_pkg.sv
rtl/core/fcc_front.sv
rtl/core/fcc_back.sv
rtl/core/frustum_cull_classifier.sv
tb/sv/tb_frustum_cull_classifier.sv
